>>> rtl/core/clce_pkg.sv
// Shared types and constants for the circular list cursor engine.
package clce_pkg;

  localparam int unsigned CLCE_CAPACITY    = 16;
  localparam int unsigned CLCE_VALUE_WIDTH = 32;

  typedef enum logic [2:0] {
    ACT_INSERT   = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_FORWARD  = 3'd2,
    ACT_BACKWARD = 3'd3,
    ACT_READ     = 3'd4,
    ACT_CLEAR    = 3'd5
  } clce_action_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2
  } clce_status_t;

endpackage

>>> rtl/core/circular_list_cursor_engine_unit.sv
// Top level of the circular list cursor engine: ring sequencer, slot map and memories.
// Insert time is set by the one-slot-a-cycle free scan; remove and backward time is set
// by the predecessor walk on the link RAM port.
// One item is in flight at a time; the next is taken once the sequencer is back in idle.
// Reset empties the ring and clears control; the value and link memories are not initialised.
module circular_list_cursor_engine_unit
  import clce_pkg::*;
#(
  parameter int unsigned CAPACITY    = CLCE_CAPACITY,
  parameter int unsigned VALUE_WIDTH = CLCE_VALUE_WIDTH,
  localparam int unsigned SLOT_W     = $clog2(CAPACITY),
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_action,
  input  logic signed [VALUE_WIDTH-1:0] in_new_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_current_value,
  output logic                          out_is_empty,
  output logic [CNT_W-1:0]              out_entry_count,
  output logic [1:0]                    out_status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INS_LINK,
    ST_WALK,
    ST_FWD,
    ST_VAL_CAP,
    ST_FINISH
  } state_t;

  state_t                  state_r;
  clce_action_t            act_r;
  logic [VALUE_WIDTH-1:0]  new_value_r;
  logic [CAPACITY-1:0]     slot_used_r;
  logic [SLOT_W-1:0]       cursor_r;
  logic [CNT_W-1:0]        live_r;
  logic [SLOT_W-1:0]       scan_r;
  logic [SLOT_W-1:0]       pred_r;
  logic [SLOT_W-1:0]       succ_r;
  logic                    first_r;
  logic [VALUE_WIDTH-1:0]  res_value_r;
  clce_status_t            res_status_r;
  logic                    out_valid_r;
  logic [VALUE_WIDTH-1:0]  out_value_r;
  logic                    out_empty_r;
  logic [CNT_W-1:0]        out_count_r;
  logic [1:0]              out_status_r;

  logic                    link_we;
  logic [SLOT_W-1:0]       link_waddr;
  logic [SLOT_W-1:0]       link_wdata;
  logic                    link_re;
  logic [SLOT_W-1:0]       link_raddr;
  logic [SLOT_W-1:0]       link_rdata;
  logic                    val_we;
  logic [SLOT_W-1:0]       val_waddr;
  logic [VALUE_WIDTH-1:0]  val_wdata;
  logic                    val_re;
  logic [SLOT_W-1:0]       val_raddr;
  logic [VALUE_WIDTH-1:0]  val_rdata;
  logic [SLOT_W-1:0]       walk_succ;
  logic                    accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign walk_succ = first_r ? link_rdata : succ_r;

  clce_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  clce_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .re    (val_re),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  always_comb begin
    link_we    = 1'b0;
    link_waddr = cursor_r;
    link_wdata = scan_r;
    link_re    = 1'b0;
    link_raddr = cursor_r;
    val_we     = 1'b0;
    val_waddr  = scan_r;
    val_wdata  = new_value_r;
    val_re     = 1'b0;
    val_raddr  = cursor_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          link_re = 1'b1;
          val_re  = 1'b1;
        end
      end
      ST_SCAN: begin
        if (!slot_used_r[scan_r]) begin
          val_we     = 1'b1;
          link_we    = 1'b1;
          link_waddr = scan_r;
          link_wdata = (live_r == '0) ? scan_r : link_rdata;
        end
      end
      ST_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = cursor_r;
        link_wdata = scan_r;
      end
      ST_WALK: begin
        if (link_rdata == cursor_r) begin
          val_re = 1'b1;
          if (act_r == ACT_REMOVE) begin
            link_we    = 1'b1;
            link_waddr = pred_r;
            link_wdata = walk_succ;
            val_raddr  = walk_succ;
          end else begin
            val_raddr  = pred_r;
          end
        end else begin
          link_re    = 1'b1;
          link_raddr = link_rdata;
        end
      end
      ST_FWD: begin
        val_re    = 1'b1;
        val_raddr = link_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_used_r  <= '0;
      cursor_r     <= '0;
      live_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            act_r        <= clce_action_t'(in_action);
            new_value_r  <= in_new_value;
            res_status_r <= STAT_DONE;
            res_value_r  <= '0;
            scan_r       <= '0;
            pred_r       <= cursor_r;
            first_r      <= 1'b1;
            if (in_action == ACT_INSERT) begin
              if (live_r == CNT_W'(CAPACITY)) begin
                res_status_r <= STAT_FULL;
                state_r      <= ST_VAL_CAP;
              end else begin
                state_r      <= ST_SCAN;
              end
            end else if (live_r == '0) begin
              res_status_r <= STAT_EMPTY;
              state_r      <= ST_FINISH;
            end else begin
              unique case (in_action)
                ACT_REMOVE: begin
                  if (live_r == CNT_W'(1)) begin
                    slot_used_r <= '0;
                    cursor_r    <= '0;
                    live_r      <= '0;
                    state_r     <= ST_FINISH;
                  end else begin
                    state_r     <= ST_WALK;
                  end
                end
                ACT_BACKWARD: state_r <= ST_WALK;
                ACT_FORWARD:  state_r <= ST_FWD;
                ACT_CLEAR: begin
                  slot_used_r <= '0;
                  cursor_r    <= '0;
                  live_r      <= '0;
                  state_r     <= ST_FINISH;
                end
                default: state_r <= ST_VAL_CAP;
              endcase
            end
          end
        end
        ST_SCAN: begin
          if (!slot_used_r[scan_r]) begin
            slot_used_r[scan_r] <= 1'b1;
            if (live_r == '0) begin
              cursor_r    <= scan_r;
              live_r      <= live_r + CNT_W'(1);
              res_value_r <= new_value_r;
              state_r     <= ST_FINISH;
            end else begin
              state_r     <= ST_INS_LINK;
            end
          end else begin
            scan_r <= scan_r + SLOT_W'(1);
          end
        end
        ST_INS_LINK: begin
          cursor_r    <= scan_r;
          live_r      <= live_r + CNT_W'(1);
          res_value_r <= new_value_r;
          state_r     <= ST_FINISH;
        end
        ST_WALK: begin
          first_r <= 1'b0;
          if (first_r) begin
            succ_r <= link_rdata;
          end
          if (link_rdata == cursor_r) begin
            if (act_r == ACT_REMOVE) begin
              slot_used_r[cursor_r] <= 1'b0;
              cursor_r              <= walk_succ;
              live_r                <= live_r - CNT_W'(1);
            end else begin
              cursor_r <= pred_r;
            end
            state_r <= ST_VAL_CAP;
          end else begin
            pred_r <= link_rdata;
          end
        end
        ST_FWD: begin
          cursor_r <= link_rdata;
          state_r  <= ST_VAL_CAP;
        end
        ST_VAL_CAP: begin
          res_value_r <= val_rdata;
          state_r     <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= (live_r == '0) ? '0 : res_value_r;
            out_empty_r  <= (live_r == '0);
            out_count_r  <= live_r;
            out_status_r <= res_status_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_value = out_value_r;
  assign out_is_empty      = out_empty_r;
  assign out_entry_count   = out_count_r;
  assign out_status        = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds the ring capacity.");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> out_entry_count == CNT_W'(CAPACITY))
    else $error("Insert rejected while the ring is not full.");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EMPTY) |-> out_is_empty && (out_entry_count == '0))
    else $error("Ignored item reported on a ring that is not empty.");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)))
    else $error("Empty flag disagrees with the entry count.");

endmodule

>>> rtl/core/clce_ram.sv
// Generic single write port, single read port RAM with registered read data.
module clce_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
